### hdl/lms_pkg.sv
// Shared types, constants and character helpers for the line-to-motor-speed frame builder.
package lms_pkg;

    // Character codes
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SP    = 8'd32;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Frame constants
    localparam logic [7:0] CMD_BYTE = 8'h02;
    localparam logic [7:0] DIR_NEG  = 8'hFF;
    localparam logic [7:0] DIR_POS  = 8'h00;

    // Field widths
    localparam int ID_W    = 11;
    localparam int SCALE_W = 4;
    localparam int WORD_W  = 16;
    localparam int ACC_W   = 32;

    // Configuration register map
    localparam int              ADDR_W      = 4;
    localparam int              DATA_W      = 32;
    localparam logic [1:0]      REG_FIRST_ID  = 2'd0;
    localparam logic [1:0]      REG_SECOND_ID = 2'd1;
    localparam logic [1:0]      REG_SCALE     = 2'd2;
    localparam logic [ID_W-1:0]    FIRST_ID_RST  = 11'd1;
    localparam logic [ID_W-1:0]    SECOND_ID_RST = 11'd0;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 4'd5;

    // Queue depths; the job queue depth matches the two store banks
    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic [ID_W-1:0]    first_id;
        logic [ID_W-1:0]    second_id;
        logic [SCALE_W-1:0] scale;
    } lms_cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              neg;
        logic [WORD_W-1:0] word;
        logic              last;
    } lms_frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN,
        ST_EMIT1,
        ST_EMIT2
    } back_state_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NUM1,
        PH_DIG1,
        PH_SEP,
        PH_NUM2,
        PH_DIG2,
        PH_DONE
    } parse_phase_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SP) || (c == CHAR_TAB);
    endfunction

    function automatic logic is_trail(input logic [7:0] c);
        return (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

### hdl/line_to_motor_speed_frames.sv
// Top level: register port, front end, line job queue, back end and result queue.
// Throughput: one byte per cycle while full is low; two finished lines may wait before full rises.
// Flow: with the back end idle, a queued line is walked over its stored bytes, then the finish
//   step runs, then the first frame is pushed to the result queue from ST_EMIT1 and the second from ST_EMIT2;
//   the back end reads one stored byte per cycle through the line store's single read port.
// Reset: queues, counters and state clear; registers load ids 1 and 0 and scale 5.
//   The line store is not cleared; only bytes of the line in progress are read.
module line_to_motor_speed_frames #(
    parameter int LINE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Byte input
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   rx_byte,
    // Frame output
    output logic                         empty,
    input  logic                         pop,
    output logic [lms_pkg::ID_W-1:0]     frame_id,
    output logic [7:0]                   command_byte,
    output logic [7:0]                   direction_byte,
    output logic signed [15:0]           speed_word,
    output logic                         last,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lms_pkg::ADDR_W-1:0]   paddr,
    input  logic [lms_pkg::DATA_W-1:0]   pwdata,
    output logic [lms_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lms_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int FW = $bits(lms_frame_t);

    logic [ID_W-1:0]    first_id_reg, second_id_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [1:0]         reg_idx;
    logic               wr_en;
    lms_cfg_t           cfg;

    logic          job_full, job_empty, job_push, job_pop;
    logic [PW-1:0] job_len_in, job_len_out;
    logic          rd_en;
    logic [PW:0]   rd_addr;
    logic [7:0]    rd_data;

    logic          res_full, res_push;
    lms_frame_t    res_frame, res_head;
    logic [FW-1:0] res_pop_data;

    // Register port: write in the access cycle, read back by index
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg  <= FIRST_ID_RST;
            second_id_reg <= SECOND_ID_RST;
            scale_reg     <= SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FIRST_ID:  first_id_reg  <= pwdata[ID_W-1:0];
                REG_SECOND_ID: second_id_reg <= pwdata[ID_W-1:0];
                REG_SCALE:     scale_reg     <= pwdata[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FIRST_ID:  prdata = DATA_W'(first_id_reg);
            REG_SECOND_ID: prdata = DATA_W'(second_id_reg);
            REG_SCALE:     prdata = DATA_W'(scale_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.first_id  = first_id_reg;
    assign cfg.second_id = second_id_reg;
    assign cfg.scale     = scale_reg;

    lms_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .job_full (job_full),
        .job_push (job_push),
        .job_len  (job_len_in),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    lms_fifo #(
        .WIDTH (PW),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_len_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_len_out),
        .empty     (job_empty)
    );

    lms_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_len   (job_len_out),
        .job_pop   (job_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .cfg       (cfg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_frame (res_frame)
    );

    lms_fifo #(
        .WIDTH (FW),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_frame),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_pop_data),
        .empty     (empty)
    );

    // Expand the queued frame onto the result ports
    assign res_head       = lms_frame_t'(res_pop_data);
    assign frame_id       = res_head.id;
    assign command_byte   = CMD_BYTE;
    assign direction_byte = res_head.neg ? DIR_NEG : DIR_POS;
    assign speed_word     = $signed(res_head.word);
    assign last           = res_head.last;

endmodule

### hdl/lms_fifo.sv
// Small synchronous queue with registered entries and a fill count.
module lms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry data
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/lms_front.sv
// Front end: takes bytes, fills the two-bank line store and queues lines with visible text.
module lms_front #(
    parameter int LINE_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [7:0]                      rx_byte,
    output logic                            full,
    input  logic                            job_full,
    output logic                            job_push,
    output logic [$clog2(LINE_DEPTH)-1:0]   job_len,
    input  logic                            rd_en,
    input  logic [$clog2(LINE_DEPTH):0]     rd_addr,
    output logic [7:0]                      rd_data
);
    import lms_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int AW = PW + 1;

    logic [7:0]    store_mem [2**AW];
    logic [7:0]    rd_data_reg;
    logic [PW-1:0] fill_reg, fill_next;
    logic          bank_reg, bank_next;
    logic          text_reg, text_next;
    logic          accept, room, term;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign room   = (fill_reg < PW'(LINE_DEPTH - 1));
    assign term   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);

    // Classify the byte: store it, track visible text, close the line on CR or LF
    always_comb
    begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        text_next = text_reg;
        job_push  = 1'b0;
        job_len   = fill_reg;
        if (accept)
        begin
            if (term)
            begin
                fill_next = '0;
                text_next = 1'b0;
                if (text_reg)
                begin
                    job_push  = 1'b1;
                    bank_next = !bank_reg;
                end
            end
            else if (room)
            begin
                fill_next = fill_reg + PW'(1);
                text_next = text_reg || !is_trail(rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
            text_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            text_reg <= text_next;
        end
    end

    // Write the line store; drop bytes past the line limit and line ends
    always_ff @(posedge clk)
    begin
        if (accept && !term && room)
        begin
            store_mem[{bank_reg, fill_reg}] <= rx_byte;
        end
    end

    // Registered read for the back end
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/lms_back.sv
// Back end: walks a queued line, parses two speeds and builds the two frames.
module lms_back #(
    parameter int LINE_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_empty,
    input  logic [$clog2(LINE_DEPTH)-1:0]   job_len,
    output logic                            job_pop,
    output logic                            rd_en,
    output logic [$clog2(LINE_DEPTH):0]     rd_addr,
    input  logic [7:0]                      rd_data,
    input  lms_pkg::lms_cfg_t               cfg,
    input  logic                            res_full,
    output logic                            res_push,
    output lms_pkg::lms_frame_t             res_frame
);
    import lms_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH);

    back_state_t       state_reg, state_next;
    parse_phase_t      phase_reg, phase_next, ph;
    logic [PW-1:0]     issue_reg, issue_next;
    logic [PW-1:0]     len_reg, len_next;
    logic              bank_reg, bank_next;
    logic              vld_reg, vld_next;
    logic [ACC_W-1:0]  acc1_reg, acc1_next, acc2_reg, acc2_next;
    logic              neg1_reg, neg1_next, neg2_reg, neg2_next;
    logic              sgn1_reg, sgn1_next, sgn2_reg, sgn2_next;
    logic [WORD_W-1:0] mag1_reg, mag1_next, mag2_reg, mag2_next;

    // Parse step signals
    logic [ACC_W-1:0]  cur, sum, dig_ext, a1, a2;
    logic              n1, n2, used;
    logic [3:0]        dig;

    // Finish and scale signals
    logic [ACC_W-1:0]          s1, s2;
    logic                      sgn_sel;
    logic [WORD_W-1:0]         mag_sel, word_pos, word;
    logic [WORD_W+SCALE_W-1:0] prod;

    // Multiply-accumulate one decimal digit
    assign dig     = 4'(rd_data - CHAR_ZERO);
    assign dig_ext = ACC_W'(dig);
    assign cur     = (phase_reg == PH_DIG2) ? acc2_reg : acc1_reg;
    assign sum     = (cur << 3) + (cur << 1) + dig_ext;

    // Advance the parse by one byte; a non-matching byte falls through to the next phase
    always_comb
    begin
        ph   = phase_reg;
        a1   = acc1_reg;
        a2   = acc2_reg;
        n1   = neg1_reg;
        n2   = neg2_reg;
        used = 1'b0;
        if (ph == PH_LEAD)
        begin
            if (is_blank(rd_data))
            begin
                used = 1'b1;
            end
            else
            begin
                ph = PH_NUM1;
            end
        end
        if (!used && ph == PH_NUM1)
        begin
            if (rd_data == CHAR_MINUS)
            begin
                n1 = 1'b1;
                ph = PH_DIG1;
                used = 1'b1;
            end
            else if (is_digit(rd_data))
            begin
                a1 = dig_ext;
                ph = PH_DIG1;
                used = 1'b1;
            end
            else
            begin
                ph = PH_SEP;
            end
        end
        else if (!used && ph == PH_DIG1)
        begin
            if (is_digit(rd_data))
            begin
                a1 = sum;
                used = 1'b1;
            end
            else
            begin
                ph = PH_SEP;
            end
        end
        if (!used && ph == PH_SEP)
        begin
            if (rd_data == CHAR_SP)
            begin
                used = 1'b1;
            end
            else
            begin
                ph = PH_NUM2;
            end
        end
        if (!used && ph == PH_NUM2)
        begin
            if (rd_data == CHAR_MINUS)
            begin
                n2 = 1'b1;
                ph = PH_DIG2;
                used = 1'b1;
            end
            else if (is_digit(rd_data))
            begin
                a2 = dig_ext;
                ph = PH_DIG2;
                used = 1'b1;
            end
            else
            begin
                ph = PH_DONE;
            end
        end
        else if (!used && ph == PH_DIG2)
        begin
            if (is_digit(rd_data))
            begin
                a2 = sum;
            end
            else
            begin
                ph = PH_DONE;
            end
        end
    end

    // Apply sign, then take sign and low magnitude bits of each speed
    assign s1 = neg1_reg ? (ACC_W'(0) - acc1_reg) : acc1_reg;
    assign s2 = neg2_reg ? (ACC_W'(0) - acc2_reg) : acc2_reg;

    // Scale the selected speed and restore its sign
    assign sgn_sel  = (state_reg == ST_EMIT2) ? sgn2_reg : sgn1_reg;
    assign mag_sel  = (state_reg == ST_EMIT2) ? mag2_reg : mag1_reg;
    assign prod     = mag_sel * cfg.scale;
    assign word_pos = prod[WORD_W-1:0];
    assign word     = sgn_sel ? (WORD_W'(0) - word_pos) : word_pos;

    // Sequence the line walk, the finish step and the two frames
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        issue_next = issue_reg;
        len_next   = len_reg;
        bank_next  = bank_reg;
        vld_next   = 1'b0;
        acc1_next  = acc1_reg;
        acc2_next  = acc2_reg;
        neg1_next  = neg1_reg;
        neg2_next  = neg2_reg;
        sgn1_next  = sgn1_reg;
        sgn2_next  = sgn2_reg;
        mag1_next  = mag1_reg;
        mag2_next  = mag2_reg;
        job_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = {bank_reg, issue_reg};
        res_push   = 1'b0;
        res_frame.id   = cfg.first_id;
        res_frame.neg  = sgn_sel;
        res_frame.word = word;
        res_frame.last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    len_next   = job_len;
                    issue_next = '0;
                    phase_next = PH_LEAD;
                    acc1_next  = '0;
                    acc2_next  = '0;
                    neg1_next  = 1'b0;
                    neg2_next  = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue_reg != len_reg)
                begin
                    rd_en      = 1'b1;
                    vld_next   = 1'b1;
                    issue_next = issue_reg + PW'(1);
                end
                else if (!vld_reg)
                begin
                    state_next = ST_FIN;
                end
                if (vld_reg)
                begin
                    phase_next = ph;
                    acc1_next  = a1;
                    acc2_next  = a2;
                    neg1_next  = n1;
                    neg2_next  = n2;
                end
            end
            ST_FIN:
            begin
                sgn1_next  = s1[ACC_W-1];
                sgn2_next  = s2[ACC_W-1];
                mag1_next  = s1[ACC_W-1] ? (WORD_W'(0) - s1[WORD_W-1:0]) : s1[WORD_W-1:0];
                mag2_next  = s2[ACC_W-1] ? (WORD_W'(0) - s2[WORD_W-1:0]) : s2[WORD_W-1:0];
                job_pop    = 1'b1;
                bank_next  = !bank_reg;
                state_next = ST_EMIT1;
            end
            ST_EMIT1:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_EMIT2;
                end
            end
            ST_EMIT2:
            begin
                res_frame.id   = cfg.second_id;
                res_frame.last = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LEAD;
            issue_reg <= '0;
            len_reg   <= '0;
            bank_reg  <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            issue_reg <= issue_next;
            len_reg   <= len_next;
            bank_reg  <= bank_next;
            vld_reg   <= vld_next;
        end
    end

    // Hold parse and speed values
    always_ff @(posedge clk)
    begin
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        neg1_reg <= neg1_next;
        neg2_reg <= neg2_next;
        sgn1_reg <= sgn1_next;
        sgn2_reg <= sgn2_next;
        mag1_reg <= mag1_next;
        mag2_reg <= mag2_next;
    end

endmodule

### hdl/lms_checker.sv
// Port-level checks on the frame output of the top level, and their binding.
module lms_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     empty,
    input logic                     pop,
    input logic [lms_pkg::ID_W-1:0] frame_id,
    input logic [7:0]               command_byte,
    input logic [7:0]               direction_byte,
    input logic signed [15:0]       speed_word,
    input logic                     last
);
    import lms_pkg::*;

    logic last_exp_reg;

    // Track which frame of the pair is due next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_exp_reg <= 1'b0;
        end
        else if (pop && !empty)
        begin
            last_exp_reg <= !last_exp_reg;
        end
    end

    // Frames leave in pairs: first then second
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == last_exp_reg))
        else $error("frame order broken: last flag out of pair sequence");

    a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (command_byte == CMD_BYTE))
        else $error("command byte is not the fixed speed command");

    a_dir_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (direction_byte == DIR_NEG || direction_byte == DIR_POS))
        else $error("direction byte is neither negative nor positive code");

    // A waiting frame holds until transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_id) && $stable(speed_word)
                              && $stable(last)))
        else $error("waiting frame changed before transfer");

endmodule

bind line_to_motor_speed_frames lms_checker u_lms_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the line-to-motor-speed frame builder.
`timescale 1ns / 100ps

module testbench;
    import lms_pkg::*;

    localparam int LINE_MAX       = 16;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 6;
    localparam int PHASE_BYTES    = 280;

    // Tracks the line being typed and the frames it must produce
    class speed_frame_board;
        typedef struct {
            logic [ID_W-1:0]   id;
            logic [7:0]        dir;
            logic [WORD_W-1:0] word;
            logic              last_flag;
        } frame_t;

        logic [7:0]         line_buf[LINE_MAX];
        int unsigned        line_len;
        logic [ID_W-1:0]    first_id;
        logic [ID_W-1:0]    second_id;
        logic [SCALE_W-1:0] scale;
        frame_t             expected_frames[$];
        int                 fail_count;

        function new();
            line_len   = 0;
            first_id   = FIRST_ID_RST;
            second_id  = SECOND_ID_RST;
            scale      = SCALE_RST;
            fail_count = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FIRST_ID:  first_id  = value[ID_W-1:0];
                REG_SECOND_ID: second_id = value[ID_W-1:0];
                REG_SCALE:     scale     = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Character of the trimmed text; zero past its end
        function logic [7:0] char_at(int unsigned pos, int unsigned stop);
            if (pos > stop || pos >= LINE_MAX)
                return 8'd0;
            return line_buf[pos];
        endfunction

        // Read an optional minus and digits; the accumulator wraps at 32 bits
        function logic [31:0] read_speed(inout int unsigned pos, input int unsigned stop);
            logic [31:0] acc;
            logic        minus;
            acc   = 32'd0;
            minus = 1'b0;
            if (char_at(pos, stop) == CHAR_MINUS) begin
                minus = 1'b1;
                pos++;
            end
            while (char_at(pos, stop) >= CHAR_ZERO && char_at(pos, stop) <= CHAR_NINE) begin
                acc = acc * 32'd10 + {24'd0, char_at(pos, stop) - CHAR_ZERO};
                pos++;
            end
            if (minus)
                acc = 32'd0 - acc;
            return acc;
        endfunction

        // Scale the magnitude, truncate to the word, then restore the sign
        function void add_frame(logic [ID_W-1:0] id, logic [31:0] speed, logic last_flag);
            frame_t      f;
            logic [31:0] mag;
            logic [31:0] prod;
            mag         = speed[31] ? 32'd0 - speed : speed;
            prod        = mag * {28'd0, scale};
            f.id        = id;
            f.dir       = speed[31] ? DIR_NEG : DIR_POS;
            f.word      = speed[31] ? 16'd0 - prod[15:0] : prod[15:0];
            f.last_flag = last_flag;
            expected_frames.push_back(f);
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned head;
            int unsigned tail;
            int unsigned pos;
            logic [31:0] s1;
            logic [31:0] s2;
            // Store up to one less than the buffer depth; drop the rest
            if (line_len < LINE_MAX - 1) begin
                line_buf[line_len] = b;
                line_len++;
            end
            if (b != CHAR_LF && b != CHAR_CR)
                return;
            // Trim leading blanks and trailing blanks and line ends
            head = 0;
            while (head < line_len && (line_buf[head] == CHAR_SP || line_buf[head] == CHAR_TAB))
                head++;
            tail = line_len;
            while (tail > head && (line_buf[tail-1] == CHAR_SP || line_buf[tail-1] == CHAR_TAB ||
                                   line_buf[tail-1] == CHAR_CR || line_buf[tail-1] == CHAR_LF))
                tail--;
            line_len = 0;
            if (tail <= head)
                return;
            pos = head;
            s1  = read_speed(pos, tail - 1);
            while (char_at(pos, tail - 1) == CHAR_SP)
                pos++;
            s2 = read_speed(pos, tail - 1);
            add_frame(first_id, s1, 1'b0);
            add_frame(second_id, s2, 1'b1);
        endfunction

        function void check_value(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("time %0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, exp_v, act_v);
                fail_count++;
            end
        endfunction

        function void check_frame(logic [ID_W-1:0] id, logic [7:0] cmd, logic [7:0] dir,
                                  logic [WORD_W-1:0] word, logic last_flag);
            frame_t f;
            if (expected_frames.size() == 0) begin
                $display("time %0t: frame with none expected, expected nothing, actual id %0h word %0h",
                         $time, id, word);
                fail_count++;
                return;
            end
            f = expected_frames.pop_front();
            check_value("frame_id", f.id, id);
            check_value("command_byte", CMD_BYTE, cmd);
            check_value("direction_byte", f.dir, dir);
            check_value("speed_word", f.word, word);
            check_value("last", f.last_flag, last_flag);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           rx_byte;
    logic                 empty;
    logic                 pop;
    logic [ID_W-1:0]      frame_id;
    logic [7:0]           command_byte;
    logic [7:0]           direction_byte;
    logic signed [15:0]   speed_word;
    logic                 last;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    speed_frame_board board = new();
    logic [7:0]       line_q[$];
    bit               quiet;
    bit               rx_hold_req;
    int               idle_cycles;

    line_to_motor_speed_frames u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .frame_id       (frame_id),
        .command_byte   (command_byte),
        .direction_byte (direction_byte),
        .speed_word     (speed_word),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one byte until its transfer, then maybe idle for a burst
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        board.note_byte(b);
        if (!quiet && $urandom_range(0, 15) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    // Stop sending, let every frame arrive and the back end settle
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register with random upper bits, then read it back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value, input int width);
        logic [31:0] mask;
        logic [31:0] wdata;
        mask  = (32'd1 << width) - 32'd1;
        wdata = ($urandom & ~mask) | (value & mask);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, wdata);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.check_value("register readback", value & mask, prdata & mask);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void add_blanks(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            line_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
    endfunction

    // Optional minus and a digit run, now and then long enough to wrap
    function automatic void add_number();
        int n;
        if ($urandom_range(0, 1))
            line_q.push_back(CHAR_MINUS);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (n)
            line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endfunction

    // Mostly well-formed speed pairs; the rest blank, overlong or noisy lines
    function automatic void build_line();
        int kind;
        int r;
        line_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            add_blanks(0, 2);
            add_number();
            if ($urandom_range(0, 9) == 0)
                add_blanks(0, 2);
            else
                repeat ($urandom_range(1, 2)) line_q.push_back(CHAR_SP);
            add_number();
            add_blanks(0, 2);
        end
        else if (kind < 75)
            add_blanks(0, 3);
        else if (kind < 85)
        begin
            repeat ($urandom_range(15, 24))
            begin
                r = $urandom_range(0, 11);
                line_q.push_back(r < 10 ? 8'(CHAR_ZERO + r) : (r == 10 ? CHAR_SP : CHAR_MINUS));
            end
        end
        else
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 7) == 0)
            line_q.push_back(CHAR_LF);
    endfunction

    // Receiver: random pop bursts, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                for (int i = 1; i < RX_HOLD_CYCLES; i++)
                    @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Check each frame transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_frame(frame_id, command_byte, direction_byte, speed_word, last);
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || psel)
            idle_cycles = 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles++;
    end

    initial
    begin
        int                 phase;
        int unsigned        sent;
        logic [ID_W-1:0]    id_a;
        logic [ID_W-1:0]    id_b;
        logic [SCALE_W-1:0] sc;
        rst_n       = 1'b0;
        push        = 1'b0;
        rx_byte     = 8'd0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        rx_hold_req = 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Blanks around a pair with a negative, empty line, lone minus
        line_q = '{CHAR_TAB, CHAR_SP, "7", CHAR_SP, CHAR_MINUS, "8", CHAR_SP, CHAR_LF};
        send_line();
        line_q = '{CHAR_CR};
        send_line();
        line_q = '{CHAR_MINUS, CHAR_LF};
        send_line();
        // Non-numeric extremes of the byte, then the most negative speed and minus zero
        line_q = '{8'hFF, 8'h00, CHAR_LF};
        send_line();
        line_q = '{CHAR_MINUS, "2", "1", "4", "7", "4", "8", "3", "6", "4", "8",
                   CHAR_SP, CHAR_MINUS, "0", CHAR_CR};
        send_line();

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                case (phase)
                    1: begin id_a = 11'd2047; id_b = 11'd0;    sc = 4'd15; end
                    2: begin id_a = 11'd0;    id_b = 11'd2047; sc = 4'd1;  end
                    3: begin id_a = 11'($urandom); id_b = 11'($urandom); sc = 4'd0; end
                    default:
                    begin
                        id_a = 11'($urandom);
                        id_b = 11'($urandom);
                        sc   = 4'($urandom_range(1, 15));
                    end
                endcase
                write_reg(REG_FIRST_ID, {21'd0, id_a}, ID_W);
                write_reg(REG_SECOND_ID, {21'd0, id_b}, ID_W);
                write_reg(REG_SCALE, {28'd0, sc}, SCALE_W);
            end
            if (phase == 1)
                rx_hold_req = 1'b1;
            if (phase == PHASES - 1)
                quiet = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_line();
                sent += line_q.size();
                send_line();
            end
        end

        wait_idle();
        if (board.fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
